/* rtl/lob_pkg.sv */
`default_nettype none

package lob_pkg;

	// Default sizes of the book.
	localparam int ORDER_ID_SPACE_DEF  = 65536;
	localparam int LEVELS_PER_SIDE_DEF = 256;
	localparam int PRICE_BITS_DEF      = 32;
	localparam int SIZE_BITS_DEF       = 32;

	// Command codes on the input item.
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_MODIFY = 3'd2;
	localparam logic [2:0] CMD_QUERY  = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	// Status codes on the result item.
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STS_DUPLICATE = 2'd2;
	localparam logic [1:0] STS_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] order_id;
		logic        side;
		logic [31:0] quantity;
		logic [31:0] price;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        best_bid_present;
		logic [31:0] best_bid_price;
		logic [31:0] best_bid_volume;
		logic        best_ask_present;
		logic [31:0] best_ask_price;
		logic [31:0] best_ask_volume;
		logic [31:0] level_volume;
		logic [15:0] level_orders;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_REMOVE,
		OP_MODIFY,
		OP_QUERY,
		OP_CLEAR,
		OP_NOP
	} op_t;

	// An item after classification by the front end.
	typedef struct packed {
		op_t  op;
		logic id_ok;
		cmd_t cmd;
	} cls_item_t;

	// Head of the command queue as seen by the engine.
	typedef struct packed {
		logic      valid;
		cls_item_t item;
	} fq_t;

	typedef struct packed {
		logic init_busy;
		logic idle;
	} eng_status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_ORD_RD,
		S_ORD_CHK,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_POST,
		S_UPD1,
		S_UPD2,
		S_SH_RD,
		S_SH_WR,
		S_FIN,
		S_BEST_B,
		S_BEST_A,
		S_BEST_C,
		S_RESP
	} eng_state_t;

endpackage

`default_nettype wire

/* rtl/limit_order_book.sv */
`default_nettype none

// Limit order book with price level aggregation. Items enter through a
// two-entry command queue and results leave through a two-entry result queue,
// so each side may stall on its own. Commands are carried out one at a time by
// a sequencer around two single-port-read memories: the order table, and the
// level table holding both sides sorted by price. An item reads up to
// LEVELS_PER_SIDE levels on its side while it scans for its price, and an
// insertion or deletion moves the levels above it; each scan or move step is
// one memory read and one compare or write. A clear command writes every
// order table entry. After reset the same sweep clears all ORDER_ID_SPACE
// entries (65536 at the default size), and full stays high until it is done.
module limit_order_book #(
	parameter int ORDER_ID_SPACE  = lob_pkg::ORDER_ID_SPACE_DEF,
	parameter int LEVELS_PER_SIDE = lob_pkg::LEVELS_PER_SIDE_DEF,
	parameter int PRICE_BITS      = lob_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS       = lob_pkg::SIZE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire lob_pkg::cmd_t cmd,
	output logic               empty,
	input  wire logic          pop,
	output lob_pkg::rsp_t      rsp
);

	logic                 front_full;
	logic                 accept;
	lob_pkg::fq_t         fq;
	logic                 fq_pop;
	logic                 e_res_valid;
	lob_pkg::rsp_t        e_rsp;
	logic                 res_ready;
	logic                 res_push;
	logic                 res_pop;
	lob_pkg::eng_status_t est;
	lob_pkg::rsp_t        rq_q [2];
	logic                 rq_wp_q;
	logic                 rq_rp_q;
	logic [1:0]           rq_cnt_q;

	assign full   = front_full | est.init_busy;
	assign accept = push & ~full;

	lob_front #(.ORDER_ID_SPACE(ORDER_ID_SPACE)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.cmd    (cmd),
		.q_full (front_full),
		.fq     (fq),
		.fq_pop (fq_pop)
	);

	lob_engine #(
		.ORDER_ID_SPACE  (ORDER_ID_SPACE),
		.LEVELS_PER_SIDE (LEVELS_PER_SIDE),
		.PRICE_BITS      (PRICE_BITS),
		.SIZE_BITS       (SIZE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fq        (fq),
		.fq_pop    (fq_pop),
		.res_valid (e_res_valid),
		.rsp       (e_rsp),
		.res_ready (res_ready),
		.est       (est)
	);

	// Result queue towards the consumer.
	assign res_ready = (rq_cnt_q != 2'd2);
	assign res_push  = e_res_valid & res_ready;
	assign res_pop   = pop & ~empty;

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[rq_wp_q] <= e_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wp_q  <= 1'b0;
			rq_rp_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				rq_wp_q <= ~rq_wp_q;
			end
			if (res_pop) begin
				rq_rp_q <= ~rq_rp_q;
			end
			rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(res_pop);
		end
	end

	assign empty = (rq_cnt_q == 2'd0);
	assign rsp   = rq_q[rq_rp_q];

	// The result queue never holds more than two items.
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q != 2'd3)
		else $error("result queue count out of range");

	// The reset sweep produces no result.
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		est.init_busy |-> !e_res_valid)
		else $error("result offered during reset sweep");

	// When the reset sweep ends no result is waiting.
	a_init_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(est.init_busy) |-> empty)
		else $error("result present at end of reset sweep");

	// An idle engine offers nothing.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		est.idle |-> !e_res_valid)
		else $error("idle engine offers a result");

endmodule

`default_nettype wire

/* rtl/lob_ram.sv */
`default_nettype none

module lob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; a read of the address
	// being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/lob_front.sv */
`default_nettype none

module lob_front #(
	parameter int ORDER_ID_SPACE = lob_pkg::ORDER_ID_SPACE_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire lob_pkg::cmd_t cmd,
	output logic               q_full,
	output lob_pkg::fq_t       fq,
	input  wire logic          fq_pop
);

	localparam logic [20:0] SPACE = 21'(ORDER_ID_SPACE);

	lob_pkg::cls_item_t cls;
	lob_pkg::cls_item_t mem_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;

	// Decode the command and check the id against the table size.
	always_comb begin
		cls.cmd   = cmd;
		cls.id_ok = 21'(cmd.order_id) < SPACE;
		unique case (cmd.command)
			lob_pkg::CMD_ADD:    cls.op = lob_pkg::OP_ADD;
			lob_pkg::CMD_REMOVE: cls.op = lob_pkg::OP_REMOVE;
			lob_pkg::CMD_MODIFY: cls.op = lob_pkg::OP_MODIFY;
			lob_pkg::CMD_QUERY:  cls.op = lob_pkg::OP_QUERY;
			lob_pkg::CMD_CLEAR:  cls.op = lob_pkg::OP_CLEAR;
			default:             cls.op = lob_pkg::OP_NOP;
		endcase
	end

	// Two-entry queue between the front end and the engine.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (fq_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(fq_pop);
		end
	end

	assign q_full   = (cnt_q == 2'd2);
	assign fq.valid = (cnt_q != 2'd0);
	assign fq.item  = mem_q[rp_q];

endmodule

`default_nettype wire

/* rtl/lob_engine.sv */
`default_nettype none

module lob_engine #(
	parameter int ORDER_ID_SPACE  = lob_pkg::ORDER_ID_SPACE_DEF,
	parameter int LEVELS_PER_SIDE = lob_pkg::LEVELS_PER_SIDE_DEF,
	parameter int PRICE_BITS      = lob_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS       = lob_pkg::SIZE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lob_pkg::fq_t      fq,
	output logic                   fq_pop,
	output logic                   res_valid,
	output lob_pkg::rsp_t          rsp,
	input  wire logic              res_ready,
	output lob_pkg::eng_status_t   est
);

	localparam int PW     = (PRICE_BITS < 32) ? PRICE_BITS : 32;
	localparam int QW     = (SIZE_BITS < 32) ? SIZE_BITS : 32;
	localparam int IAW    = $clog2(ORDER_ID_SPACE);
	localparam int LW     = $clog2(LEVELS_PER_SIDE);
	localparam int LCW    = $clog2(LEVELS_PER_SIDE + 1);
	localparam int CW     = $clog2(ORDER_ID_SPACE + 1);
	localparam int OE_W   = 2 + PW + QW;
	localparam int LE_W   = PW + 64 + CW;
	localparam int LDEPTH = 2 * (2 ** LW);
	localparam logic [31:0]    VOL_LIM = 32'((64'd1 << QW) - 64'd1);
	localparam logic [IAW-1:0] ID_LAST = IAW'(ORDER_ID_SPACE - 1);
	localparam logic [LCW-1:0] L_FULL  = LCW'(LEVELS_PER_SIDE);

	function automatic logic [31:0] vol_out(input logic [63:0] v);
		vol_out = ((v >> QW) != 64'd0) ? VOL_LIM : v[31:0];
	endfunction

	function automatic logic [15:0] cnt_out(input logic [CW-1:0] c);
		cnt_out = (32'(c) > 32'hFFFF) ? 16'hFFFF : 16'(c);
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [QW-1:0] b);
		logic [64:0] s;
		s = {1'b0, a} + 65'(b);
		sat_add = s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [63:0] clamp_sub(input logic [63:0] a, input logic [QW-1:0] b);
		clamp_sub = (a > 64'(b)) ? (a - 64'(b)) : 64'd0;
	endfunction

	lob_pkg::eng_state_t state_q, state_d;
	logic [LCW-1:0] bid_n_q, bid_n_d, ask_n_q, ask_n_d, n_cur;
	logic           clr_reply_q, clr_reply_d;
	logic [IAW-1:0] clr_addr_q, clr_addr_d;

	lob_pkg::op_t   op_q, op_d;
	logic [IAW-1:0] id_q, id_d;
	logic           side_q, side_d;
	logic [QW-1:0]  qty_q, qty_d, old_q, old_d;
	logic [PW-1:0]  price_q, price_d;
	logic           act_q, act_d, found_q, found_d;
	logic [1:0]     status_q, status_d;
	logic [LCW-1:0] idx_q, idx_d;
	logic [LW-1:0]  j_q, j_d;
	logic [63:0]    lvol_q, lvol_d;
	logic [CW-1:0]  lcnt_q, lcnt_d;
	logic [31:0]    rvol_q, rvol_d;
	logic [15:0]    rcnt_q, rcnt_d;
	logic           bb_pres_q, bb_pres_d, ba_pres_q, ba_pres_d;
	logic [31:0]    bb_price_q, bb_price_d, bb_vol_q, bb_vol_d;
	logic [31:0]    ba_price_q, ba_price_d, ba_vol_q, ba_vol_d;

	logic            ord_we;
	logic [IAW-1:0]  ord_waddr;
	logic [OE_W-1:0] ord_wdata, ord_rdata;
	logic            lvl_we;
	logic [LW:0]     lvl_waddr, lvl_raddr;
	logic [LE_W-1:0] lvl_wdata, lvl_rdata;

	logic           o_live, o_side;
	logic [PW-1:0]  o_price, e_price;
	logic [QW-1:0]  o_size;
	logic [63:0]    e_vol;
	logic [CW-1:0]  e_cnt;

	// Order table: live, side, price and size per id.
	lob_ram #(.WIDTH(OE_W), .DEPTH(ORDER_ID_SPACE)) u_ord_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (id_q),
		.rdata (ord_rdata)
	);

	// Level tables of both sides, addressed by side and sorted position.
	lob_ram #(.WIDTH(LE_W), .DEPTH(LDEPTH)) u_lvl_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_waddr),
		.wdata (lvl_wdata),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	assign o_live  = ord_rdata[OE_W-1];
	assign o_side  = ord_rdata[OE_W-2];
	assign o_price = ord_rdata[QW +: PW];
	assign o_size  = ord_rdata[QW-1:0];
	assign e_price = lvl_rdata[LE_W-1 -: PW];
	assign e_vol   = lvl_rdata[CW +: 64];
	assign e_cnt   = lvl_rdata[CW-1:0];
	assign n_cur   = side_q ? ask_n_q : bid_n_q;

	// Sequencer: clear sweep, order lookup, level scan, update, shift and best-price read.
	always_comb begin
		state_d     = state_q;
		bid_n_d     = bid_n_q;
		ask_n_d     = ask_n_q;
		clr_reply_d = clr_reply_q;
		clr_addr_d  = clr_addr_q;
		op_d        = op_q;
		id_d        = id_q;
		side_d      = side_q;
		qty_d       = qty_q;
		old_d       = old_q;
		price_d     = price_q;
		act_d       = act_q;
		found_d     = found_q;
		status_d    = status_q;
		idx_d       = idx_q;
		j_d         = j_q;
		lvol_d      = lvol_q;
		lcnt_d      = lcnt_q;
		rvol_d      = rvol_q;
		rcnt_d      = rcnt_q;
		bb_pres_d   = bb_pres_q;
		bb_price_d  = bb_price_q;
		bb_vol_d    = bb_vol_q;
		ba_pres_d   = ba_pres_q;
		ba_price_d  = ba_price_q;
		ba_vol_d    = ba_vol_q;
		fq_pop      = 1'b0;
		res_valid   = 1'b0;
		ord_we      = 1'b0;
		ord_waddr   = id_q;
		ord_wdata   = {1'b1, side_q, price_q, qty_q};
		lvl_we      = 1'b0;
		lvl_waddr   = {side_q, idx_q[LW-1:0]};
		lvl_wdata   = {price_q, lvol_q, lcnt_q};
		lvl_raddr   = {side_q, idx_q[LW-1:0]};

		unique case (state_q)
			lob_pkg::S_CLR: begin
				ord_we    = 1'b1;
				ord_waddr = clr_addr_q;
				ord_wdata = '0;
				bid_n_d   = '0;
				ask_n_d   = '0;
				if (clr_addr_q == ID_LAST) begin
					clr_addr_d = '0;
					if (clr_reply_q) begin
						status_d = lob_pkg::STS_OK;
						rvol_d   = 32'd0;
						rcnt_d   = 16'd0;
						state_d  = lob_pkg::S_BEST_B;
					end else begin
						state_d = lob_pkg::S_IDLE;
					end
				end else begin
					clr_addr_d = clr_addr_q + 1'b1;
				end
			end
			lob_pkg::S_IDLE: begin
				if (fq.valid) begin
					fq_pop      = 1'b1;
					op_d        = fq.item.op;
					id_d        = IAW'(fq.item.cmd.order_id);
					side_d      = fq.item.cmd.side;
					qty_d       = fq.item.cmd.quantity[QW-1:0];
					price_d     = fq.item.cmd.price[PW-1:0];
					status_d    = lob_pkg::STS_OK;
					act_d       = 1'b0;
					idx_d       = '0;
					clr_reply_d = (fq.item.op == lob_pkg::OP_CLEAR);
					unique case (fq.item.op)
						lob_pkg::OP_CLEAR: begin
							clr_addr_d = '0;
							state_d    = lob_pkg::S_CLR;
						end
						lob_pkg::OP_NOP: begin
							rvol_d  = 32'd0;
							rcnt_d  = 16'd0;
							state_d = lob_pkg::S_BEST_B;
						end
						lob_pkg::OP_QUERY: begin
							state_d = lob_pkg::S_SRCH_RD;
						end
						lob_pkg::OP_ADD: begin
							if (fq.item.id_ok) begin
								state_d = lob_pkg::S_ORD_RD;
							end else begin
								status_d = lob_pkg::STS_FULL;
								state_d  = lob_pkg::S_SRCH_RD;
							end
						end
						lob_pkg::OP_REMOVE, lob_pkg::OP_MODIFY: begin
							if (fq.item.id_ok) begin
								state_d = lob_pkg::S_ORD_RD;
							end else begin
								status_d = lob_pkg::STS_NOT_FOUND;
								state_d  = lob_pkg::S_SRCH_RD;
							end
						end
						default: begin
							state_d = lob_pkg::S_IDLE;
						end
					endcase
				end
			end
			lob_pkg::S_ORD_RD: begin
				state_d = lob_pkg::S_ORD_CHK;
			end
			lob_pkg::S_ORD_CHK: begin
				// Remove and modify address the level the order was placed at.
				if (op_q == lob_pkg::OP_ADD) begin
					if (o_live) begin
						status_d = lob_pkg::STS_DUPLICATE;
					end else begin
						act_d = 1'b1;
					end
				end else if (o_live) begin
					side_d  = o_side;
					price_d = o_price;
					old_d   = o_size;
					act_d   = 1'b1;
				end else begin
					status_d = lob_pkg::STS_NOT_FOUND;
				end
				state_d = lob_pkg::S_SRCH_RD;
			end
			lob_pkg::S_SRCH_RD: begin
				if (idx_q < n_cur) begin
					state_d = lob_pkg::S_SRCH_CMP;
				end else begin
					found_d = 1'b0;
					state_d = lob_pkg::S_POST;
				end
			end
			lob_pkg::S_SRCH_CMP: begin
				if (e_price < price_q) begin
					idx_d   = idx_q + 1'b1;
					state_d = lob_pkg::S_SRCH_RD;
				end else begin
					found_d = (e_price == price_q);
					lvol_d  = e_vol;
					lcnt_d  = e_cnt;
					state_d = lob_pkg::S_POST;
				end
			end
			lob_pkg::S_POST: begin
				if (!act_q) begin
					rvol_d = found_q ? vol_out(lvol_q) : 32'd0;
					rcnt_d = found_q ? cnt_out(lcnt_q) : 16'd0;
					if (op_q == lob_pkg::OP_QUERY && !found_q) begin
						status_d = lob_pkg::STS_NOT_FOUND;
					end
					state_d = lob_pkg::S_BEST_B;
				end else if (found_q) begin
					state_d = lob_pkg::S_UPD1;
				end else if (op_q == lob_pkg::OP_ADD) begin
					if (n_cur >= L_FULL) begin
						status_d = lob_pkg::STS_FULL;
						rvol_d   = 32'd0;
						rcnt_d   = 16'd0;
						state_d  = lob_pkg::S_BEST_B;
					end else if (idx_q < n_cur) begin
						j_d     = LW'(n_cur - 1'b1);
						state_d = lob_pkg::S_SH_RD;
					end else begin
						state_d = lob_pkg::S_FIN;
					end
				end else begin
					state_d = lob_pkg::S_FIN;
				end
			end
			lob_pkg::S_UPD1: begin
				// Remove and modify take the old size off first; add and modify add the new size next cycle.
				if (op_q != lob_pkg::OP_ADD) begin
					lvol_d = clamp_sub(lvol_q, old_q);
				end
				if (op_q == lob_pkg::OP_ADD) begin
					lcnt_d = lcnt_q + 1'b1;
				end else if (op_q == lob_pkg::OP_REMOVE && lcnt_q != '0) begin
					lcnt_d = lcnt_q - 1'b1;
				end
				state_d = lob_pkg::S_UPD2;
			end
			lob_pkg::S_UPD2: begin
				if (op_q != lob_pkg::OP_REMOVE) begin
					lvol_d = sat_add(lvol_q, qty_q);
				end
				if (op_q == lob_pkg::OP_REMOVE && lcnt_q == '0
						&& (idx_q + LCW'(1)) < n_cur) begin
					j_d     = LW'(idx_q + LCW'(1));
					state_d = lob_pkg::S_SH_RD;
				end else begin
					state_d = lob_pkg::S_FIN;
				end
			end
			lob_pkg::S_SH_RD: begin
				lvl_raddr = {side_q, j_q};
				state_d   = lob_pkg::S_SH_WR;
			end
			lob_pkg::S_SH_WR: begin
				// Insertion moves entries up from the top, deletion moves them down.
				lvl_we    = 1'b1;
				lvl_wdata = lvl_rdata;
				if (op_q == lob_pkg::OP_ADD) begin
					lvl_waddr = {side_q, LW'(j_q + 1'b1)};
					if (j_q == idx_q[LW-1:0]) begin
						state_d = lob_pkg::S_FIN;
					end else begin
						j_d     = j_q - 1'b1;
						state_d = lob_pkg::S_SH_RD;
					end
				end else begin
					lvl_waddr = {side_q, LW'(j_q - 1'b1)};
					if ((LCW'(j_q) + LCW'(1)) == n_cur) begin
						state_d = lob_pkg::S_FIN;
					end else begin
						j_d     = j_q + 1'b1;
						state_d = lob_pkg::S_SH_RD;
					end
				end
			end
			lob_pkg::S_FIN: begin
				ord_we = 1'b1;
				rvol_d = 32'd0;
				rcnt_d = 16'd0;
				unique case (op_q)
					lob_pkg::OP_ADD: begin
						lvl_we = 1'b1;
						if (found_q) begin
							rvol_d = vol_out(lvol_q);
							rcnt_d = cnt_out(lcnt_q);
						end else begin
							lvl_wdata = {price_q, 64'(qty_q), CW'(1)};
							rvol_d    = vol_out(64'(qty_q));
							rcnt_d    = 16'd1;
							if (side_q) begin
								ask_n_d = ask_n_q + 1'b1;
							end else begin
								bid_n_d = bid_n_q + 1'b1;
							end
						end
					end
					lob_pkg::OP_REMOVE: begin
						ord_wdata = '0;
						if (found_q) begin
							if (lcnt_q == '0) begin
								if (side_q) begin
									ask_n_d = ask_n_q - 1'b1;
								end else begin
									bid_n_d = bid_n_q - 1'b1;
								end
							end else begin
								lvl_we = 1'b1;
								rvol_d = vol_out(lvol_q);
								rcnt_d = cnt_out(lcnt_q);
							end
						end
					end
					lob_pkg::OP_MODIFY: begin
						if (found_q) begin
							lvl_we = 1'b1;
							rvol_d = vol_out(lvol_q);
							rcnt_d = cnt_out(lcnt_q);
						end
					end
					default: begin
						ord_we = 1'b0;
					end
				endcase
				state_d = lob_pkg::S_BEST_B;
			end
			lob_pkg::S_BEST_B: begin
				lvl_raddr = {1'b0, LW'(bid_n_q - 1'b1)};
				state_d   = lob_pkg::S_BEST_A;
			end
			lob_pkg::S_BEST_A: begin
				bb_pres_d  = (bid_n_q != '0);
				bb_price_d = (bid_n_q != '0) ? 32'(e_price) : 32'd0;
				bb_vol_d   = (bid_n_q != '0) ? vol_out(e_vol) : 32'd0;
				lvl_raddr  = {1'b1, LW'(0)};
				state_d    = lob_pkg::S_BEST_C;
			end
			lob_pkg::S_BEST_C: begin
				ba_pres_d  = (ask_n_q != '0);
				ba_price_d = (ask_n_q != '0) ? 32'(e_price) : 32'd0;
				ba_vol_d   = (ask_n_q != '0) ? vol_out(e_vol) : 32'd0;
				state_d    = lob_pkg::S_RESP;
			end
			lob_pkg::S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = lob_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lob_pkg::S_IDLE;
			end
		endcase
	end

	// Control state; reset starts the sweep that clears the order table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lob_pkg::S_CLR;
			bid_n_q     <= '0;
			ask_n_q     <= '0;
			clr_reply_q <= 1'b0;
			clr_addr_q  <= '0;
		end else begin
			state_q     <= state_d;
			bid_n_q     <= bid_n_d;
			ask_n_q     <= ask_n_d;
			clr_reply_q <= clr_reply_d;
			clr_addr_q  <= clr_addr_d;
		end
	end

	// Working registers of the item in progress.
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		id_q       <= id_d;
		side_q     <= side_d;
		qty_q      <= qty_d;
		old_q      <= old_d;
		price_q    <= price_d;
		act_q      <= act_d;
		found_q    <= found_d;
		status_q   <= status_d;
		idx_q      <= idx_d;
		j_q        <= j_d;
		lvol_q     <= lvol_d;
		lcnt_q     <= lcnt_d;
		rvol_q     <= rvol_d;
		rcnt_q     <= rcnt_d;
		bb_pres_q  <= bb_pres_d;
		bb_price_q <= bb_price_d;
		bb_vol_q   <= bb_vol_d;
		ba_pres_q  <= ba_pres_d;
		ba_price_q <= ba_price_d;
		ba_vol_q   <= ba_vol_d;
	end

	assign rsp.status           = status_q;
	assign rsp.best_bid_present = bb_pres_q;
	assign rsp.best_bid_price   = bb_price_q;
	assign rsp.best_bid_volume  = bb_vol_q;
	assign rsp.best_ask_present = ba_pres_q;
	assign rsp.best_ask_price   = ba_price_q;
	assign rsp.best_ask_volume  = ba_vol_q;
	assign rsp.level_volume     = rvol_q;
	assign rsp.level_orders     = rcnt_q;

	assign est.init_busy = (state_q == lob_pkg::S_CLR) && !clr_reply_q;
	assign est.idle      = (state_q == lob_pkg::S_IDLE);

endmodule

`default_nettype wire
